// ===== sv/lwc_pkg.sv =====
`default_nettype none
package lwc_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int OUT_WIDTH = 32;
  localparam int NUM_COUNTERS = 6;
  localparam int INC_WIDTH = 3;

  // counter bank slots
  localparam int C_WCH = 0;
  localparam int C_MCH = 1;
  localparam int C_WHT = 2;
  localparam int C_WRD = 3;
  localparam int C_CMD = 4;
  localparam int C_ENV = 5;

  localparam logic [20:0] CH_BSLASH = 21'h00005C;
  localparam logic [20:0] CH_PCT    = 21'h000025;
  localparam logic [20:0] CH_RBRACE = 21'h00007D;
  localparam logic [20:0] CH_TILDE  = 21'h00007E;
  localparam logic [20:0] CH_CARET  = 21'h00005E;
  localparam logic [20:0] CH_NL     = 21'h00000A;
  localparam logic [20:0] CH_B      = 21'h000062;
  localparam logic [20:0] CH_E      = 21'h000065;
  localparam logic [20:0] CH_G      = 21'h000067;
  localparam logic [20:0] CH_I      = 21'h000069;
  localparam logic [20:0] CH_N      = 21'h00006E;
  localparam logic [20:0] CH_D      = 21'h000064;

  typedef enum logic [10:0] {
    MODE_STD  = 11'b00000000001,
    MODE_CMT  = 11'b00000000010,
    MODE_CSEQ = 11'b00000000100,
    MODE_CMD  = 11'b00000001000,
    MODE_ENV  = 11'b00000010000,
    MODE_B1   = 11'b00000100000,
    MODE_B2   = 11'b00001000000,
    MODE_B3   = 11'b00010000000,
    MODE_B4   = 11'b00100000000,
    MODE_E1   = 11'b01000000000,
    MODE_E2   = 11'b10000000000
  } lwc_mode_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic        is_letter;
    logic        is_digit;
    logic        is_punct;
    logic        first_of_string;
    logic        last_of_string;
    logic        start_of_batch;
  } lwc_item_t;

  typedef struct packed {
    logic [31:0] word_chars;
    logic [31:0] markup_chars;
    logic [31:0] white_chars;
    logic [31:0] word_total;
    logic [31:0] command_total;
    logic [31:0] environment_total;
    logic        newline_error;
  } lwc_result_t;

  // characters already consumed by a partial begin or end match
  function automatic logic [INC_WIDTH-1:0] held_chars(input lwc_mode_t m);
    logic [INC_WIDTH-1:0] r;
    unique case (m)
      MODE_B1: r = INC_WIDTH'(1);
      MODE_B2: r = INC_WIDTH'(2);
      MODE_B3: r = INC_WIDTH'(3);
      MODE_B4: r = INC_WIDTH'(4);
      MODE_E1: r = INC_WIDTH'(1);
      MODE_E2: r = INC_WIDTH'(2);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [OUT_WIDTH-1:0] to_out(input logic [COUNT_WIDTH-1:0] c);
    logic [COUNT_WIDTH+OUT_WIDTH-1:0] ext;
    ext = {{OUT_WIDTH{1'b0}}, c};
    return ext[OUT_WIDTH-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== sv/latex_word_counter_unit.sv =====
// a request accepted into the input register has its result valid in the result register once that register moves
// throughput: one request per cycle while the result register is not stalled, one result per request, in order
// the result register stalls the input register only while result_stall holds
// rst (synchronous, active high) clears the parse mode, word flags, all six
// counters, the newline error and both valid flags
`default_nettype none
module latex_word_counter_unit
  import lwc_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         item_valid,
  output logic        item_stall,
  input  lwc_item_t   item,
  output logic        result_valid,
  input  wire         result_stall,
  output lwc_result_t result
);

  logic      s1_valid;
  lwc_item_t s1_item;

  lwc_mode_t mode, mode_next;
  logic      in_word, in_word_next;
  logic      pending, pending_next;
  logic      error_seen, error_next;
  logic [COUNT_WIDTH-1:0] cnt [NUM_COUNTERS];
  logic [COUNT_WIDTH-1:0] cnt_next [NUM_COUNTERS];

  logic out_adv, s1_move;

  lwc_mode_t mode_cur;
  logic [20:0] c;
  logic letter, cmd_char, resolve;
  logic [INC_WIDTH-1:0] inc [NUM_COUNTERS];
  logic [COUNT_WIDTH-1:0] base;
  logic [COUNT_WIDTH:0] sum [NUM_COUNTERS];

  assign out_adv = !result_valid || !result_stall;
  assign s1_move = s1_valid && out_adv;
  assign item_stall = s1_valid && !out_adv;

  always_comb begin
    c = s1_item.code_point;
    letter = s1_item.is_letter;
    mode_cur = s1_item.first_of_string ? MODE_STD : mode;
    in_word_next = s1_item.first_of_string ? 1'b0 : in_word;
    pending_next = s1_item.first_of_string ? 1'b0 : pending;
    error_next = s1_item.start_of_batch ? 1'b0 : error_seen;
    if (c == CH_NL) begin
      error_next = 1'b1;
    end
    for (int k = 0; k < NUM_COUNTERS; k++) begin
      inc[k] = '0;
    end
    cmd_char = 1'b0;
    resolve = 1'b0;
    mode_next = mode_cur;

    // word reset armed by a backslash on the previous character
    if (pending_next) begin
      if (!s1_item.is_punct || c == CH_TILDE || c == CH_CARET) begin
        in_word_next = 1'b0;
      end
      pending_next = 1'b0;
    end

    unique case (mode_cur)
      MODE_STD: begin
        if (c == CH_BSLASH) begin
          mode_next = MODE_CSEQ;
          inc[C_MCH] = INC_WIDTH'(1);
          pending_next = 1'b1;
        end else if (c == CH_PCT) begin
          mode_next = MODE_CMT;
        end else if (letter || s1_item.is_digit) begin
          if (letter && !in_word_next) begin
            in_word_next = 1'b1;
            inc[C_WRD] = INC_WIDTH'(1);
          end
          inc[C_WCH] = INC_WIDTH'(1);
        end else begin
          inc[C_WHT] = INC_WIDTH'(1);
          in_word_next = 1'b0;
        end
      end
      MODE_CSEQ: begin
        if (letter && c == CH_B) begin
          mode_next = MODE_B1;
        end else if (letter && c == CH_E) begin
          mode_next = MODE_E1;
        end else begin
          inc[C_CMD] = INC_WIDTH'(1);
          inc[C_MCH] = INC_WIDTH'(1);
          mode_next = letter ? MODE_CMD : MODE_STD;
        end
      end
      MODE_CMD: cmd_char = 1'b1;
      MODE_ENV: begin
        if (c == CH_RBRACE) begin
          inc[C_MCH] = INC_WIDTH'(1);
          mode_next = MODE_STD;
        end else if (c == CH_PCT) begin
          mode_next = MODE_CMT;
        end else begin
          inc[C_MCH] = INC_WIDTH'(1);
        end
      end
      MODE_CMT: ;
      MODE_B1: if (c == CH_E) mode_next = MODE_B2; else resolve = 1'b1;
      MODE_B2: if (c == CH_G) mode_next = MODE_B3; else resolve = 1'b1;
      MODE_B3: if (c == CH_I) mode_next = MODE_B4; else resolve = 1'b1;
      MODE_B4: begin
        if (c == CH_N) begin
          inc[C_ENV] = INC_WIDTH'(1);
          inc[C_MCH] = INC_WIDTH'(5);
          mode_next = MODE_ENV;
        end else begin
          resolve = 1'b1;
        end
      end
      MODE_E1: if (c == CH_N) mode_next = MODE_E2; else resolve = 1'b1;
      MODE_E2: begin
        if (c == CH_D) begin
          inc[C_MCH] = INC_WIDTH'(3);
          mode_next = MODE_ENV;
        end else begin
          resolve = 1'b1;
        end
      end
      default: mode_next = MODE_STD;
    endcase

    // mismatch inside begin or end: count a command, then treat the char as command text
    if (resolve) begin
      inc[C_CMD] = inc[C_CMD] + INC_WIDTH'(1);
      inc[C_MCH] = inc[C_MCH] + held_chars(mode_cur);
      mode_next = MODE_CMD;
      cmd_char = 1'b1;
    end

    if (cmd_char) begin
      if (letter) begin
        inc[C_MCH] = inc[C_MCH] + INC_WIDTH'(1);
      end else if (c == CH_BSLASH) begin
        inc[C_MCH] = inc[C_MCH] + INC_WIDTH'(1);
        mode_next = MODE_CSEQ;
      end else if (c == CH_PCT) begin
        mode_next = MODE_CMT;
      end else begin
        inc[C_WHT] = inc[C_WHT] + INC_WIDTH'(1);
        mode_next = MODE_STD;
      end
    end

    // end of string settles a partial match as a command
    if (s1_item.last_of_string) begin
      if (held_chars(mode_next) != '0) begin
        inc[C_CMD] = inc[C_CMD] + INC_WIDTH'(1);
        inc[C_MCH] = inc[C_MCH] + held_chars(mode_next);
        mode_next = MODE_CMD;
      end
      pending_next = 1'b0;
    end

    for (int k = 0; k < NUM_COUNTERS; k++) begin
      base = s1_item.start_of_batch ? '0 : cnt[k];
      sum[k] = {1'b0, base} + (COUNT_WIDTH+1)'(inc[k]);
      cnt_next[k] = sum[k][COUNT_WIDTH] ? '1 : sum[k][COUNT_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      result_valid <= 1'b0;
      mode <= MODE_STD;
      in_word <= 1'b0;
      pending <= 1'b0;
      error_seen <= 1'b0;
      for (int k = 0; k < NUM_COUNTERS; k++) begin
        cnt[k] <= '0;
      end
    end else begin
      if (!item_stall) begin
        s1_valid <= item_valid;
      end
      if (out_adv) begin
        result_valid <= s1_valid;
      end
      if (s1_move) begin
        mode <= mode_next;
        in_word <= in_word_next;
        pending <= pending_next;
        error_seen <= error_next;
        for (int k = 0; k < NUM_COUNTERS; k++) begin
          cnt[k] <= cnt_next[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      s1_item <= item;
    end
    if (s1_move) begin
      result.word_chars <= to_out(cnt_next[C_WCH]);
      result.markup_chars <= to_out(cnt_next[C_MCH]);
      result.white_chars <= to_out(cnt_next[C_WHT]);
      result.word_total <= to_out(cnt_next[C_WRD]);
      result.command_total <= to_out(cnt_next[C_CMD]);
      result.environment_total <= to_out(cnt_next[C_ENV]);
      result.newline_error <= error_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/lwc_checker.sv =====
`default_nettype none
module lwc_checker
  import lwc_pkg::*;
(
  input wire         clk,
  input wire         rst,
  input wire         item_valid,
  input wire         item_stall,
  input lwc_item_t   item,
  input wire         result_valid,
  input wire         result_stall,
  input lwc_result_t result
);

  // a held result stays put until taken
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // a stalled request is held as offered
  a_request_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_stall |=> item_valid && $stable(item))
    else $error("request changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && !item_stall)
    else $error("not empty after reset");

  // with the result slot empty the block always takes a request
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !item_stall)
    else $error("request stalled with empty result slot");

  // a request taken while the result slot is empty is shown once the result slot can move
  a_latency: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && !result_valid ##1 !result_stall |=> result_valid)
    else $error("result missing after request");

endmodule

bind latex_word_counter_unit lwc_checker u_lwc_checker (.*);
`default_nettype wire
